### sv/convex_hull_graham_scan_unit_defines.svh
// Assertion macros for the convex hull Graham scan unit.
// Used by the top level; needs signals clk_i and rst_ni in the including scope.
`ifndef CONVEX_HULL_GRAHAM_SCAN_UNIT_DEFINES_SVH
`define CONVEX_HULL_GRAHAM_SCAN_UNIT_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define CHGS_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("chgs assertion failed");

// Next-cycle implication, disabled during reset.
`define CHGS_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("chgs assertion failed");

`endif

### sv/chgs_pkg.sv
// Shared types for the convex hull Graham scan unit.
// No dependencies.
`default_nettype none

package chgs_pkg;

  // Sign summary of one orientation (cross product) result.
  typedef struct packed {
    logic valid;
    logic zero;
    logic pos;
  } cross_res_t;

endpackage

`default_nettype wire

### sv/chgs_ram.sv
// Single-port-write, single-port-read synchronous RAM with registered read data.
// No dependencies.
`default_nettype none

module chgs_ram #(
  parameter int W     = 32,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [W-1:0]             wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [W-1:0]             rdata_o
);

  logic [W-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

`default_nettype wire

### sv/chgs_cross.sv
// Three-stage orientation unit: sign of (b - a) x (c - a).
// Depends on chgs_pkg for the result struct.
`default_nettype none

module chgs_cross
  import chgs_pkg::*;
#(
  parameter int CW = 16
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            start_i,
  input  wire logic [2*CW-1:0] a_i,
  input  wire logic [2*CW-1:0] b_i,
  input  wire logic [2*CW-1:0] c_i,
  output cross_res_t           res_o
);

  localparam int DW = CW + 1;
  localparam int PW = 2 * DW;

  logic signed [DW-1:0] dbx_q, dby_q, dcx_q, dcy_q;
  logic signed [PW-1:0] p1_q, p2_q;
  logic signed [PW:0]   diff;
  logic                 v1_q, v2_q;

  // Points are packed as {x, y}.
  always_ff @(posedge clk_i) begin
    dbx_q <= DW'($signed(b_i[2*CW-1:CW])) - DW'($signed(a_i[2*CW-1:CW]));
    dby_q <= DW'($signed(b_i[CW-1:0]))    - DW'($signed(a_i[CW-1:0]));
    dcx_q <= DW'($signed(c_i[2*CW-1:CW])) - DW'($signed(a_i[2*CW-1:CW]));
    dcy_q <= DW'($signed(c_i[CW-1:0]))    - DW'($signed(a_i[CW-1:0]));
    p1_q  <= PW'(dbx_q) * PW'(dcy_q);
    p2_q  <= PW'(dby_q) * PW'(dcx_q);
  end

  assign diff = (PW+1)'(p1_q) - (PW+1)'(p2_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q  <= 1'b0;
      v2_q  <= 1'b0;
      res_o <= '0;
    end else begin
      v1_q        <= start_i;
      v2_q        <= v1_q;
      res_o.valid <= v2_q;
      res_o.zero  <= (diff == '0);
      res_o.pos   <= !diff[PW] && (diff != '0);
    end
  end

endmodule

`default_nettype wire

### sv/convex_hull_graham_scan_unit.sv
// Convex hull by Graham scan: top level with the sequencer and two point memories.
// Depends on chgs_pkg, chgs_ram, chgs_cross and the defines header.
//
//  Channel  | Handshake                    | Payload
//  ---------+------------------------------+--------------------------------------
//  input    | start_i, busy_o (take: !busy)| px_i, py_i, final_point_i
//  result   | result_valid_o (one cycle)   | hx_o, hy_o, last_vertex_o, degenerate_o
//
// A point item that is not final is taken and the block stays ready.
// A final item starts a run with busy_o high, paced by registered memory reads and the
// orientation unit: a pivot search, an insertion sort (O(n^2) steps worst case),
// deduplication, stack pushes and pops for a hull that is not degenerate, then the
// emission of the hull vertices.
// Reset clears the point count and the sequencer; the memories are not cleared.
// The receiver cannot stall: each result is shown for exactly one cycle.
`default_nettype none

module convex_hull_graham_scan_unit
  import chgs_pkg::*;
#(
  parameter int MAX_POINTS = 64,
  parameter int COORD_BITS = 16
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         start_i,
  output logic                              busy_o,
  input  wire logic signed [COORD_BITS-1:0] px_i,
  input  wire logic signed [COORD_BITS-1:0] py_i,
  input  wire logic                         final_point_i,
  output logic                              result_valid_o,
  output logic signed [COORD_BITS-1:0]      hx_o,
  output logic signed [COORD_BITS-1:0]      hy_o,
  output logic                              last_vertex_o,
  output logic                              degenerate_o
);

`include "convex_hull_graham_scan_unit_defines.svh"

  localparam int CB   = COORD_BITS;
  localparam int PTW  = 2 * CB;
  localparam int IW   = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int CNTW = $clog2(MAX_POINTS + 1);
  localparam int LW   = CB + 2;

  // Sequencer states.
  localparam logic [4:0] S_IDLE    = 5'd0;
  localparam logic [4:0] S_PV_RD   = 5'd1;
  localparam logic [4:0] S_PV_CHK  = 5'd2;
  localparam logic [4:0] S_SO_RD   = 5'd3;
  localparam logic [4:0] S_SO_GET  = 5'd4;
  localparam logic [4:0] S_INS     = 5'd5;
  localparam logic [4:0] S_INS_Q   = 5'd6;
  localparam logic [4:0] S_INS_W   = 5'd7;
  localparam logic [4:0] S_DD_RD   = 5'd8;
  localparam logic [4:0] S_DD_GET  = 5'd9;
  localparam logic [4:0] S_DD_W    = 5'd10;
  localparam logic [4:0] S_DD_END  = 5'd11;
  localparam logic [4:0] S_SC_INIT = 5'd12;
  localparam logic [4:0] S_SC_RD   = 5'd13;
  localparam logic [4:0] S_SC_GET  = 5'd14;
  localparam logic [4:0] S_SC_CHK  = 5'd15;
  localparam logic [4:0] S_SC_W    = 5'd16;
  localparam logic [4:0] S_SC_LDA  = 5'd17;
  localparam logic [4:0] S_EM_RD   = 5'd18;
  localparam logic [4:0] S_EM_OUT  = 5'd19;

  logic [4:0]      state_q, state_d;
  logic [CNTW-1:0] cnt_q, cnt_d;
  logic [CNTW-1:0] i_q, i_d, j_q, j_d, m_q, m_d, kept_q, kept_d, top_q, top_d, k_q, k_d;
  logic            degen_q, degen_d;
  logic            xstart_q, xstart_d;

  // Payload registers (points packed as {x, y}).
  logic [PTW-1:0] pv_q, pv_d, p_q, p_d, q_q, q_d, sa_q, sa_d, sb_q, sb_d;
  logic [PTW-1:0] ca_q, ca_d, cb_q, cb_d, cc_q, cc_d;
  logic [PTW-1:0] out_q, out_d;
  logic           ovalid_q, ovalid_d, olast_q, olast_d, odegen_q, odegen_d;

  // Memory ports. The point memory later holds the hull stack.
  logic           pt_we, ord_we;
  logic [IW-1:0]  pt_waddr, pt_raddr, ord_waddr, ord_raddr;
  logic [PTW-1:0] pt_wdata, pt_rdata, ord_wdata, ord_rdata;
  cross_res_t     xres;

  chgs_ram #(.W(PTW), .DEPTH(MAX_POINTS)) u_pt_ram (
    .clk_i   (clk_i),
    .we_i    (pt_we),
    .waddr_i (pt_waddr),
    .wdata_i (pt_wdata),
    .raddr_i (pt_raddr),
    .rdata_o (pt_rdata)
  );

  chgs_ram #(.W(PTW), .DEPTH(MAX_POINTS)) u_ord_ram (
    .clk_i   (clk_i),
    .we_i    (ord_we),
    .waddr_i (ord_waddr),
    .wdata_i (ord_wdata),
    .raddr_i (ord_raddr),
    .rdata_o (ord_rdata)
  );

  chgs_cross #(.CW(CB)) u_cross (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (xstart_q),
    .a_i     (ca_q),
    .b_i     (cb_q),
    .c_i     (cc_q),
    .res_o   (xres)
  );

  // Collinear points about the pivot all lie on one ray with dy >= 0, so
  // |dx| + dy orders them by distance just as the squared distance does.
  function automatic logic [LW-1:0] ray_len(input logic [PTW-1:0] pt,
                                            input logic [PTW-1:0] pv);
    logic signed [CB:0] dx;
    logic signed [CB:0] dy;
    logic [CB:0]        ax;
    dx = (CB+1)'($signed(pt[PTW-1:CB])) - (CB+1)'($signed(pv[PTW-1:CB]));
    dy = (CB+1)'($signed(pt[CB-1:0]))   - (CB+1)'($signed(pv[CB-1:0]));
    ax = dx[CB] ? (CB+1)'(-dx) : (CB+1)'(dx);
    return LW'(ax) + LW'(dy);
  endfunction

  logic signed [CB-1:0] rd_x, rd_y, pv_x, pv_y;
  logic                 after;
  logic [CNTW-1:0]      i_inc, total;

  assign rd_x  = $signed(pt_rdata[PTW-1:CB]);
  assign rd_y  = $signed(pt_rdata[CB-1:0]);
  assign pv_x  = $signed(pv_q[PTW-1:CB]);
  assign pv_y  = $signed(pv_q[CB-1:0]);
  assign i_inc = CNTW'(i_q + 1'b1);
  assign total = degen_q ? CNTW'(kept_q + 1'b1) : top_q;

  // Point q goes after point p when p x q turns counterclockwise, or on one ray when q is farther.
  assign after = xres.zero ? (ray_len(q_q, pv_q) > ray_len(p_q, pv_q)) : xres.pos;

  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    i_d       = i_q;
    j_d       = j_q;
    m_d       = m_q;
    kept_d    = kept_q;
    top_d     = top_q;
    k_d       = k_q;
    degen_d   = degen_q;
    xstart_d  = 1'b0;
    pv_d      = pv_q;
    p_d       = p_q;
    q_d       = q_q;
    sa_d      = sa_q;
    sb_d      = sb_q;
    ca_d      = ca_q;
    cb_d      = cb_q;
    cc_d      = cc_q;
    out_d     = out_q;
    ovalid_d  = 1'b0;
    olast_d   = olast_q;
    odegen_d  = odegen_q;
    pt_we     = 1'b0;
    pt_waddr  = cnt_q[IW-1:0];
    pt_wdata  = {px_i, py_i};
    pt_raddr  = i_q[IW-1:0];
    ord_we    = 1'b0;
    ord_waddr = j_q[IW-1:0];
    ord_wdata = p_q;
    ord_raddr = i_q[IW-1:0];

    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          // A full store ignores the point; a final item still runs the hull.
          if (cnt_q < CNTW'(MAX_POINTS)) begin
            pt_we = 1'b1;
            cnt_d = CNTW'(cnt_q + 1'b1);
          end
          if (final_point_i) begin
            i_d     = '0;
            state_d = S_PV_RD;
          end
        end
      end

      S_PV_RD: begin
        state_d = S_PV_CHK;
      end

      S_PV_CHK: begin
        if (i_q == '0 || rd_y < pv_y || (rd_y == pv_y && rd_x < pv_x)) begin
          pv_d = pt_rdata;
        end
        if (i_inc == cnt_q) begin
          i_d     = '0;
          m_d     = '0;
          state_d = S_SO_RD;
        end else begin
          i_d     = i_inc;
          state_d = S_PV_RD;
        end
      end

      S_SO_RD: begin
        state_d = S_SO_GET;
      end

      S_SO_GET: begin
        p_d = pt_rdata;
        j_d = m_q;
        if (pt_rdata == pv_q) begin
          // The pivot and its copies are left out of the sort.
          i_d = i_inc;
          if (i_inc == cnt_q) begin
            i_d     = '0;
            kept_d  = '0;
            state_d = (m_q == '0) ? S_EM_RD : S_DD_RD;
            degen_d = (m_q == '0);
            k_d     = '0;
          end else begin
            state_d = S_SO_RD;
          end
        end else begin
          state_d = S_INS;
        end
      end

      S_INS: begin
        if (j_q == '0) begin
          ord_we    = 1'b1;
          ord_waddr = '0;
          ord_wdata = p_q;
          m_d       = CNTW'(m_q + 1'b1);
          i_d       = i_inc;
          if (i_inc == cnt_q) begin
            i_d     = '0;
            kept_d  = '0;
            state_d = S_DD_RD;
          end else begin
            state_d = S_SO_RD;
          end
        end else begin
          ord_raddr = IW'(j_q - 1'b1);
          state_d   = S_INS_Q;
        end
      end

      S_INS_Q: begin
        q_d      = ord_rdata;
        ca_d     = pv_q;
        cb_d     = p_q;
        cc_d     = ord_rdata;
        xstart_d = 1'b1;
        state_d  = S_INS_W;
      end

      S_INS_W: begin
        if (xres.valid) begin
          ord_we = 1'b1;
          if (after) begin
            ord_wdata = q_q;
            j_d       = CNTW'(j_q - 1'b1);
            state_d   = S_INS;
          end else begin
            ord_wdata = p_q;
            m_d       = CNTW'(m_q + 1'b1);
            i_d       = i_inc;
            if (i_inc == cnt_q) begin
              i_d     = '0;
              kept_d  = '0;
              state_d = S_DD_RD;
            end else begin
              state_d = S_SO_RD;
            end
          end
        end
      end

      // Deduplication in place: q holds the previous entry, written back
      // only when the next entry leaves its direction.
      S_DD_RD: begin
        state_d = S_DD_GET;
      end

      S_DD_GET: begin
        if (i_q == '0) begin
          q_d     = ord_rdata;
          i_d     = i_inc;
          state_d = (m_q == CNTW'(1)) ? S_DD_END : S_DD_RD;
        end else begin
          p_d      = ord_rdata;
          ca_d     = pv_q;
          cb_d     = q_q;
          cc_d     = ord_rdata;
          xstart_d = 1'b1;
          state_d  = S_DD_W;
        end
      end

      S_DD_W: begin
        if (xres.valid) begin
          if (!xres.zero) begin
            ord_we    = 1'b1;
            ord_waddr = kept_q[IW-1:0];
            ord_wdata = q_q;
            kept_d    = CNTW'(kept_q + 1'b1);
          end
          q_d     = p_q;
          i_d     = i_inc;
          state_d = (i_inc == m_q) ? S_DD_END : S_DD_RD;
        end
      end

      S_DD_END: begin
        ord_we    = 1'b1;
        ord_waddr = kept_q[IW-1:0];
        ord_wdata = q_q;
        kept_d    = CNTW'(kept_q + 1'b1);
        k_d       = '0;
        if (kept_q == '0) begin
          degen_d = 1'b1;
          state_d = S_EM_RD;
        end else begin
          degen_d = 1'b0;
          state_d = S_SC_INIT;
        end
      end

      // Stack scan; the stack lives in the point memory, sa/sb cache its top two.
      S_SC_INIT: begin
        pt_we    = 1'b1;
        pt_waddr = '0;
        pt_wdata = pv_q;
        top_d    = CNTW'(1);
        sb_d     = pv_q;
        i_d      = '0;
        state_d  = S_SC_RD;
      end

      S_SC_RD: begin
        state_d = S_SC_GET;
      end

      S_SC_GET: begin
        p_d     = ord_rdata;
        state_d = S_SC_CHK;
      end

      S_SC_CHK: begin
        if (top_q > CNTW'(1)) begin
          ca_d     = sa_q;
          cb_d     = sb_q;
          cc_d     = p_q;
          xstart_d = 1'b1;
          state_d  = S_SC_W;
        end else begin
          pt_we    = 1'b1;
          pt_waddr = top_q[IW-1:0];
          pt_wdata = p_q;
          sa_d     = sb_q;
          sb_d     = p_q;
          top_d    = CNTW'(top_q + 1'b1);
          i_d      = i_inc;
          state_d  = (i_inc == kept_q) ? S_EM_RD : S_SC_RD;
        end
      end

      S_SC_W: begin
        if (xres.valid) begin
          if (!xres.pos) begin
            // Not a strict left turn: pop and refetch the new second entry.
            top_d = CNTW'(top_q - 1'b1);
            sb_d  = sa_q;
            if (top_q > CNTW'(2)) begin
              pt_raddr = IW'(top_q - 2'd3);
              state_d  = S_SC_LDA;
            end else begin
              state_d = S_SC_CHK;
            end
          end else begin
            pt_we    = 1'b1;
            pt_waddr = top_q[IW-1:0];
            pt_wdata = p_q;
            sa_d     = sb_q;
            sb_d     = p_q;
            top_d    = CNTW'(top_q + 1'b1);
            i_d      = i_inc;
            state_d  = (i_inc == kept_q) ? S_EM_RD : S_SC_RD;
          end
        end
      end

      S_SC_LDA: begin
        sa_d    = pt_rdata;
        state_d = S_SC_CHK;
      end

      S_EM_RD: begin
        ord_raddr = IW'(k_q - 1'b1);
        pt_raddr  = k_q[IW-1:0];
        state_d   = S_EM_OUT;
      end

      S_EM_OUT: begin
        ovalid_d = 1'b1;
        odegen_d = degen_q;
        olast_d  = (CNTW'(k_q + 1'b1) == total);
        if (degen_q) begin
          out_d = (k_q == '0) ? pv_q : ord_rdata;
        end else begin
          out_d = pt_rdata;
        end
        if (CNTW'(k_q + 1'b1) == total) begin
          cnt_d   = '0;
          state_d = S_IDLE;
        end else begin
          k_d     = CNTW'(k_q + 1'b1);
          state_d = S_EM_RD;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      cnt_q    <= '0;
      i_q      <= '0;
      j_q      <= '0;
      m_q      <= '0;
      kept_q   <= '0;
      top_q    <= '0;
      k_q      <= '0;
      degen_q  <= 1'b0;
      xstart_q <= 1'b0;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      cnt_q    <= cnt_d;
      i_q      <= i_d;
      j_q      <= j_d;
      m_q      <= m_d;
      kept_q   <= kept_d;
      top_q    <= top_d;
      k_q      <= k_d;
      degen_q  <= degen_d;
      xstart_q <= xstart_d;
      ovalid_q <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pv_q     <= pv_d;
    p_q      <= p_d;
    q_q      <= q_d;
    sa_q     <= sa_d;
    sb_q     <= sb_d;
    ca_q     <= ca_d;
    cb_q     <= cb_d;
    cc_q     <= cc_d;
    out_q    <= out_d;
    olast_q  <= olast_d;
    odegen_q <= odegen_d;
  end

  assign busy_o         = (state_q != S_IDLE);
  assign result_valid_o = ovalid_q;
  assign hx_o           = $signed(out_q[PTW-1:CB]);
  assign hy_o           = $signed(out_q[CB-1:0]);
  assign last_vertex_o  = olast_q;
  assign degenerate_o   = odegen_q;

  // The final vertex of a run is shown only once the sequencer is back in idle,
  // and every earlier vertex while it is still running.
  `CHGS_ASSERT_IMP(a_last_at_idle, result_valid_o && last_vertex_o, !busy_o)
  `CHGS_ASSERT_IMP(a_mid_while_busy, result_valid_o && !last_vertex_o, busy_o)
  // The point count never passes the store depth.
  `CHGS_ASSERT_NXT(a_count_bound, 1'b1, cnt_q <= CNTW'(MAX_POINTS))

endmodule

`default_nettype wire

### tb/convex_hull_graham_scan_unit_tb.sv
// Testbench for the convex hull Graham scan unit: loads point sets, predicts the hull
// in software and checks every emitted vertex. Depends on the RTL top level only.
`default_nettype none

// Holds the hull vertices that the block still owes and checks results against them.
class hull_scoreboard;
  typedef struct {
    logic signed [15:0] x;
    logic signed [15:0] y;
    bit                 last;
    bit                 degen;
  } vertex_t;

  longint  set_x[$];
  longint  set_y[$];
  vertex_t hull_q[$];
  int      mismatches;

  // Orientation of (b - a) x (c - a); positive is a left turn.
  function automatic longint orient(int a, int b, int c, longint xs[$], longint ys[$]);
    return (xs[b] - xs[a]) * (ys[c] - ys[a]) - (ys[b] - ys[a]) * (xs[c] - xs[a]);
  endfunction

  function automatic void push_vertex(longint x, longint y, bit last, bit degen);
    vertex_t v;
    v.x = x[15:0];
    v.y = y[15:0];
    v.last = last;
    v.degen = degen;
    hull_q = {hull_q, v};
  endfunction

  // Stores an accepted point; on the final point the expected hull is computed.
  function automatic void note_point(logic signed [15:0] x, logic signed [15:0] y,
                                     bit fin);
    int piv, n, j, kept_n, sp;
    int order[$];
    int kept[$];
    int stk[64];
    longint dc, da, db;
    bit after;
    if (set_x.size() < 64) begin
      set_x = {set_x, longint'(x)};
      set_y = {set_y, longint'(y)};
    end
    if (!fin) return;
    n = set_x.size();
    piv = 0;
    for (int i = 1; i < n; i++)
      if (set_y[i] < set_y[piv] || (set_y[i] == set_y[piv] && set_x[i] < set_x[piv]))
        piv = i;
    // Insertion sort by angle about the pivot, nearer first on a tie.
    for (int i = 0; i < n; i++) begin
      if (i == piv || (set_x[i] == set_x[piv] && set_y[i] == set_y[piv])) continue;
      j = order.size();
      order = {order, i};
      while (j > 0) begin
        dc = orient(piv, i, order[j-1], set_x, set_y);
        if (dc != 0) after = dc > 0;
        else begin
          da = (set_x[order[j-1]] - set_x[piv]) ** 2 + (set_y[order[j-1]] - set_y[piv]) ** 2;
          db = (set_x[i] - set_x[piv]) ** 2 + (set_y[i] - set_y[piv]) ** 2;
          after = da > db;
        end
        if (!after) break;
        order[j] = order[j-1];
        j--;
      end
      order[j] = i;
    end
    // Only the farthest point of each direction survives.
    kept = {kept, piv};
    for (int i = 0; i < order.size(); i++) begin
      while (i + 1 < order.size() && orient(piv, order[i], order[i+1], set_x, set_y) == 0)
        i++;
      kept = {kept, order[i]};
    end
    kept_n = kept.size();
    if (kept_n < 3) begin
      for (int k = 0; k < kept_n; k++)
        push_vertex(set_x[kept[k]], set_y[kept[k]], k == kept_n - 1, 1'b1);
    end else begin
      sp = 0;
      for (int i = 0; i < kept_n; i++) begin
        while (sp > 1 && orient(kept[stk[sp-2]], kept[stk[sp-1]], kept[i],
                                set_x, set_y) <= 0)
          sp--;
        stk[sp] = i;
        sp++;
      end
      for (int k = 0; k < sp; k++)
        push_vertex(set_x[kept[stk[k]]], set_y[kept[stk[k]]], k == sp - 1, 1'b0);
    end
    set_x.delete();
    set_y.delete();
  endfunction

  task automatic report(string what);
    $display("mismatch: %s", what);
    mismatches++;
  endtask

  task automatic check_vertex(logic signed [15:0] x, logic signed [15:0] y,
                              logic last, logic degen);
    vertex_t e;
    if (hull_q.size() == 0) begin
      report($sformatf("unexpected vertex (%0d,%0d)", x, y));
      return;
    end
    e = hull_q.pop_front();
    if (x !== e.x) report($sformatf("hx %0d, want %0d", x, e.x));
    if (y !== e.y) report($sformatf("hy %0d, want %0d", y, e.y));
    if (last !== e.last) report($sformatf("last_vertex %b, want %b", last, e.last));
    if (degen !== e.degen) report($sformatf("degenerate %b, want %b", degen, e.degen));
  endtask
endclass

module convex_hull_graham_scan_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               start_i = 1'b0;
  logic signed [15:0] px_i = '0;
  logic signed [15:0] py_i = '0;
  logic               final_point_i = 1'b0;
  logic               busy_o, result_valid_o, last_vertex_o, degenerate_o;
  logic signed [15:0] hx_o, hy_o;

  hull_scoreboard hulls = new();
  int sent_items;

  always #10 clk_i = ~clk_i;

  convex_hull_graham_scan_unit DUT (
    .clk_i, .rst_ni, .start_i, .busy_o, .px_i, .py_i, .final_point_i,
    .result_valid_o, .hx_o, .hy_o, .last_vertex_o, .degenerate_o
  );

  // Results cannot be held off, so every strobed cycle is checked as it ends.
  always @(posedge clk_i) begin
    if (rst_ni && result_valid_o)
      hulls.check_vertex(hx_o, hy_o, last_vertex_o, degenerate_o);
  end

  // Mostly short gaps, now and then a long one.
  function automatic int gap_len();
    int n;
    n = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30) : $urandom_range(0, 2);
    if ($urandom_range(0, 3) == 0) n = 0;
    return n;
  endfunction

  // Offers one point and holds it until the block takes it. With no gap after a
  // point that is not final, start stays high for the next point.
  task automatic send_point(logic signed [15:0] x, logic signed [15:0] y, bit fin);
    int gap;
    start_i <= 1'b1;
    px_i <= x;
    py_i <= y;
    final_point_i <= fin;
    do @(posedge clk_i); while (busy_o);
    hulls.note_point(x, y, fin);
    sent_items++;
    gap = gap_len();
    if (fin || gap != 0) start_i <= 1'b0;
    repeat (gap) @(posedge clk_i);
  endtask

  // Coordinates: full range, a small box to force collinear and repeated points,
  // or the extreme values.
  function automatic logic signed [15:0] pick_coord(int style);
    case (style)
      0: return 16'($urandom);
      1: return $signed(16'($urandom_range(0, 6))) - 16'sd3;
      default: return ($urandom_range(0, 1) != 0) ? 16'sh7fff : 16'sh8000;
    endcase
  endfunction

  // Sends a set and waits for the whole hull; the block is busy while it computes.
  task automatic send_set(int n, int style);
    for (int i = 0; i < n; i++)
      send_point(pick_coord(style), pick_coord(style), i == n - 1);
    while (hulls.hull_q.size() != 0) @(posedge clk_i);
  endtask

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // A single point is its own degenerate hull.
    send_point(16'sh8000, 16'sh7fff, 1'b1);
    while (hulls.hull_q.size() != 0) @(posedge clk_i);
    // Corners of the coordinate range, with an interior point and a collinear one.
    send_point(16'sh8000, 16'sh8000, 1'b0);
    send_point(16'sh7fff, 16'sh8000, 1'b0);
    send_point(16'sh0000, 16'sh8000, 1'b0);
    send_point(16'sh7fff, 16'sh7fff, 1'b0);
    send_point(16'sh0000, 16'sh0000, 1'b0);
    send_point(16'sh8000, 16'sh7fff, 1'b1);
    while (hulls.hull_q.size() != 0) @(posedge clk_i);
    // Copies of the pivot and all points on one line: degenerate with two kept.
    send_point(16'sd1, 16'sd1, 1'b0);
    send_point(16'sd1, 16'sd1, 1'b0);
    send_point(16'sd3, 16'sd3, 1'b0);
    send_point(16'sd2, 16'sd2, 1'b0);
    send_point(16'sd1, 16'sd1, 1'b1);
    while (hulls.hull_q.size() != 0) @(posedge clk_i);
    // Triangle with collinear points on its edges.
    send_point(16'sd0, 16'sd0, 1'b0);
    send_point(16'sd4, 16'sd0, 1'b0);
    send_point(16'sd2, 16'sd0, 1'b0);
    send_point(16'sd0, 16'sd4, 1'b0);
    send_point(16'sd0, 16'sd2, 1'b0);
    send_point(16'sd2, 16'sd2, 1'b1);
    while (hulls.hull_q.size() != 0) @(posedge clk_i);
    // An overfull store: points past the capacity are dropped.
    send_set(70, 0);

    while (sent_items < 160)
      send_set($urandom_range(1, 12), $urandom_range(0, 4) < 2 ? 0 :
               ($urandom_range(0, 3) != 0 ? 1 : 2));

    repeat (50) @(posedge clk_i);
    if (hulls.mismatches == 0 && hulls.hull_q.size() == 0) begin
      $display("convex_hull_graham_scan_unit_tb OK");
    end else begin
      $display("convex_hull_graham_scan_unit_tb NOT OK");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("convex_hull_graham_scan_unit_tb NOT OK");
    $finish;
  end
endmodule

`default_nettype wire
